[hdl/bapd_pkg.sv]
// Shared types and constants for the balance angle PD controller.
// Field widths, configuration register indexes and reset values.
// No dependencies.
package bapd_pkg;

    localparam int RAW_W        = 12;
    localparam int GAIN_W       = 24;
    localparam int ANGLE_W      = 24;
    localparam int ACCUM_W      = 48;
    localparam int DRIVE_W      = 32;
    localparam int CAL_SUM_W    = 18;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 56;

    localparam int CAL_SAMPLES_DEF = 64;

    localparam logic [RAW_W-1:0] ACCEL_ZERO_RST = 12'd2048;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACCEL_ZERO = 3'd0,
        REG_GYRO_GAIN  = 3'd1,
        REG_ACCEL_GAIN = 3'd2,
        REG_KP_GAIN    = 3'd3,
        REG_KD_GAIN    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        [RAW_W-1:0]  accel_zero;
        logic signed [GAIN_W-1:0] gyro_gain;
        logic signed [GAIN_W-1:0] accel_gain;
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] kd_gain;
    } cfg_t;

endpackage

[hdl/balance_angle_pd_controller_core.sv]
// Balance angle PD controller: gyro offset calibration, complementary filter
// angle estimate and PD motor drive. Depends on bapd_pkg, bapd_cal, bapd_filter.
// Input samples pass through an input register, then a result register. Throughput:
// one transaction per cycle while m_tready does not stall the result side; the
// accumulator is updated as each post-calibration result is registered.
// Synchronous reset clears calibration, accumulator and valid flags; config registers take reset values.
module balance_angle_pd_controller_core
    import bapd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // accel_raw[11:0], gyro_raw[23:12]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // drive[31:0], tilt_angle[55:32]
    output logic                   m_tuser,   // ready_res[0]
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    logic               in_valid_reg;
    logic [RAW_W-1:0]   accel_in_reg;
    logic [RAW_W-1:0]   gyro_in_reg;

    logic                      m_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [ANGLE_W-1:0] tilt_reg;
    logic                      ready_res_reg;

    logic                      advance;
    logic                      calibrating;
    logic [RAW_W-1:0]          rate_offset;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ANGLE_W-1:0] tilt_angle;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {tilt_reg, drive_reg};
    assign m_tuser  = ready_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_zero <= ACCEL_ZERO_RST;
            cfg_reg.gyro_gain  <= '0;
            cfg_reg.accel_gain <= '0;
            cfg_reg.kp_gain    <= '0;
            cfg_reg.kd_gain    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ACCEL_ZERO: cfg_reg.accel_zero <= cfg_data[RAW_W-1:0];
                REG_GYRO_GAIN:  cfg_reg.gyro_gain  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_ACCEL_GAIN: cfg_reg.accel_gain <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KP_GAIN:    cfg_reg.kp_gain    <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KD_GAIN:    cfg_reg.kd_gain    <= $signed(cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            accel_in_reg <= s_tdata[RAW_W-1:0];
            gyro_in_reg  <= s_tdata[2*RAW_W-1:RAW_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg     <= calibrating ? '0 : drive;
            tilt_reg      <= calibrating ? '0 : tilt_angle;
            ready_res_reg <= !calibrating;
        end
    end

    bapd_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .gyro_raw    (gyro_in_reg),
        .calibrating (calibrating),
        .rate_offset (rate_offset)
    );

    bapd_filter u_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance && !calibrating),
        .cfg         (cfg_reg),
        .accel_raw   (accel_in_reg),
        .gyro_raw    (gyro_in_reg),
        .rate_offset (rate_offset),
        .drive       (drive),
        .tilt_angle  (tilt_angle)
    );

endmodule

[hdl/bapd_cal.sv]
// Gyro offset calibration: sums the first CAL_SAMPLES gyro samples and
// divides by CAL_SAMPLES (reciprocal multiply with one correction step).
// Depends on bapd_pkg.
module bapd_cal
    import bapd_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [RAW_W-1:0] gyro_raw,
    output logic             calibrating,
    output logic [RAW_W-1:0] rate_offset
);

    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int RECIP_SH  = 24;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int PROD_W    = CAL_SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0]   RECIP   = RECIP_W'((64'd1 << RECIP_SH) / CAL_SAMPLES);
    localparam logic [CNT_W-1:0]     CNT_END = CNT_W'(CAL_SAMPLES);
    localparam logic [CAL_SUM_W-1:0] DIVISOR = CAL_SUM_W'(CAL_SAMPLES);

    logic [CAL_SUM_W-1:0] cal_sum_reg, cal_sum_next;
    logic [CNT_W-1:0]     cal_count_reg, cal_count_next;
    logic [RAW_W-1:0]     rate_offset_reg, rate_offset_next;

    logic [PROD_W-1:0]    prod;
    logic [CAL_SUM_W-1:0] quot_est;
    logic [CAL_SUM_W-1:0] quot_mul;
    logic [CAL_SUM_W-1:0] remainder;
    logic [CAL_SUM_W-1:0] quot;

    assign calibrating = cal_count_reg < CNT_END;
    assign rate_offset = rate_offset_reg;

    always_comb begin
        cal_sum_next   = cal_sum_reg + CAL_SUM_W'(gyro_raw);
        prod           = PROD_W'(cal_sum_next) * PROD_W'(RECIP);
        quot_est       = prod[RECIP_SH +: CAL_SUM_W];
        quot_mul       = CAL_SUM_W'(quot_est * DIVISOR);
        remainder      = cal_sum_next - quot_mul;
        quot           = (remainder >= DIVISOR) ? quot_est + 1'b1 : quot_est;
        cal_count_next = cal_count_reg + 1'b1;
        rate_offset_next = (cal_count_next == CNT_END) ? quot[RAW_W-1:0] : rate_offset_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_sum_reg     <= '0;
            cal_count_reg   <= '0;
            rate_offset_reg <= '0;
        end else if (step && calibrating) begin
            cal_sum_reg     <= cal_sum_next;
            cal_count_reg   <= cal_count_next;
            rate_offset_reg <= rate_offset_next;
        end
    end

endmodule

[hdl/bapd_filter.sv]
// Complementary filter angle accumulator and PD drive arithmetic.
// Holds the Q26.22 angle accumulator; drive and angle are combinational.
// Depends on bapd_pkg.
module bapd_filter
    import bapd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  cfg_t                      cfg,
    input  logic        [RAW_W-1:0]   accel_raw,
    input  logic        [RAW_W-1:0]   gyro_raw,
    input  logic        [RAW_W-1:0]   rate_offset,
    output logic signed [DRIVE_W-1:0] drive,
    output logic signed [ANGLE_W-1:0] tilt_angle
);

    localparam int SHR_W  = ACCUM_W - 10;
    localparam int ERR_W  = ANGLE_W + 2;
    localparam int WIDE_W = 50;
    localparam logic signed [SHR_W-1:0]   ANG_MAX = SHR_W'(8388607);
    localparam logic signed [SHR_W-1:0]   ANG_MIN = -SHR_W'(8388608);
    localparam logic signed [WIDE_W-1:0]  ACC_MAX = WIDE_W'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [WIDE_W-1:0]  ACC_MIN = WIDE_W'(48'sh8000_0000_0000);
    localparam logic signed [WIDE_W-1:0]  TRUNC_BIAS = WIDE_W'(24'hFF_FFFF);

    logic signed [ACCUM_W-1:0]         angle_accum_reg, angle_accum_next;
    logic signed [RAW_W:0]             accel;
    logic signed [RAW_W:0]             rate;
    logic signed [SHR_W-1:0]           acc_shr;
    logic signed [ANGLE_W-1:0]         angle;
    logic signed [ERR_W-1:0]           err;
    logic signed [RAW_W+GAIN_W:0]      gterm;
    logic signed [ERR_W+GAIN_W-1:0]    corr_full;
    logic signed [WIDE_W-1:0]          accum_sum;
    logic signed [ANGLE_W+GAIN_W-1:0]  p_term;
    logic signed [RAW_W+GAIN_W:0]      d_term;
    logic signed [WIDE_W-1:0]          drv_full;
    logic signed [WIDE_W-1:0]          drv_bias;

    always_comb begin
        accel   = $signed({1'b0, cfg.accel_zero}) - $signed({1'b0, accel_raw});
        rate    = $signed({1'b0, gyro_raw}) - $signed({1'b0, rate_offset});
        acc_shr = $signed(angle_accum_reg[ACCUM_W-1:10]);
        if (acc_shr > ANG_MAX) begin
            angle = ANGLE_W'(ANG_MAX);
        end else if (acc_shr < ANG_MIN) begin
            angle = ANGLE_W'(ANG_MIN);
        end else begin
            angle = acc_shr[ANGLE_W-1:0];
        end

        gterm     = rate * cfg.gyro_gain;
        err       = $signed({accel, 12'b0}) - ERR_W'(angle);
        corr_full = err * cfg.accel_gain;
        accum_sum = WIDE_W'(angle_accum_reg) + WIDE_W'(gterm)
                  + WIDE_W'($signed(corr_full[ERR_W+GAIN_W-1:12]));
        if (accum_sum > ACC_MAX) begin
            angle_accum_next = ACCUM_W'(ACC_MAX);
        end else if (accum_sum < ACC_MIN) begin
            angle_accum_next = ACCUM_W'(ACC_MIN);
        end else begin
            angle_accum_next = accum_sum[ACCUM_W-1:0];
        end

        p_term   = angle * cfg.kp_gain;
        d_term   = rate * cfg.kd_gain;
        drv_full = WIDE_W'(p_term) + WIDE_W'($signed({d_term, 12'b0}));
        drv_bias = drv_full + (drv_full[WIDE_W-1] ? TRUNC_BIAS : '0);
        drive    = DRIVE_W'($signed(drv_bias[WIDE_W-1:24]));
        tilt_angle = angle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_accum_reg <= '0;
        end else if (step) begin
            angle_accum_reg <= angle_accum_next;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for balance_angle_pd_controller_core: stream stimulus,
// register writes and a scoreboard class that predicts each drive transaction.
// Depends on bapd_pkg and the core RTL.
module tb;
    import bapd_pkg::*;

    localparam int CAL_N = CAL_SAMPLES_DEF;
    localparam longint ACCUM_MAX = (longint'(1) <<< (ACCUM_W - 1)) - 1;
    localparam longint ACCUM_MIN = -ACCUM_MAX - 1;
    localparam longint TILT_MAX = (longint'(1) <<< (ANGLE_W - 1)) - 1;
    localparam longint TILT_MIN = -TILT_MAX - 1;
    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -DRIVE_MAX - 1;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [GAIN_W-1:0] GAIN_POS_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
    localparam logic [GAIN_W-1:0] GAIN_NEG_MAX = {1'b1, {(GAIN_W - 1){1'b0}}};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {GAIN_FULL, GAIN_EXTREME, GAIN_MODERATE, GAIN_FINE} gain_kind_t;

    typedef struct {
        logic [DRIVE_W-1:0] drive;
        logic [ANGLE_W-1:0] tilt;
        logic               ready;
    } drive_result_t;

    class drive_scoreboard;
        longint zero_pt, k_gyro, k_accel, k_p, k_d;
        logic [CAL_SUM_W-1:0] cal_sum;
        int cal_count;
        logic [RAW_W-1:0] rate_offset;
        longint accum;
        drive_result_t expected_q[$];
        int mismatches;

        function new();
            zero_pt = longint'(ACCEL_ZERO_RST);
            k_gyro = 0;
            k_accel = 0;
            k_p = 0;
            k_d = 0;
            cal_sum = '0;
            cal_count = 0;
            rate_offset = '0;
            accum = 0;
            mismatches = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void load_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ACCEL_ZERO: zero_pt = longint'(data[RAW_W-1:0]);
                REG_GYRO_GAIN:  k_gyro  = longint'($signed(data));
                REG_ACCEL_GAIN: k_accel = longint'($signed(data));
                REG_KP_GAIN:    k_p     = longint'($signed(data));
                REG_KD_GAIN:    k_d     = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function void note_sample(logic [RAW_W-1:0] accel_raw, logic [RAW_W-1:0] gyro_raw);
            longint accel, rate, angle, corr, drv;
            drive_result_t r;
            r = '{default: '0};
            if (cal_count < CAL_N) begin
                cal_sum = cal_sum + gyro_raw;
                cal_count++;
                if (cal_count == CAL_N) rate_offset = RAW_W'(cal_sum / CAL_N);
            end else begin
                accel = zero_pt - longint'(accel_raw);
                rate = longint'(gyro_raw) - longint'(rate_offset);
                angle = clip(accum >>> 10, TILT_MIN, TILT_MAX);
                corr = ((accel * 4096) - angle) * k_accel >>> 12;
                accum = clip(accum + rate * k_gyro + corr, ACCUM_MIN, ACCUM_MAX);
                drv = angle * k_p + rate * k_d * 4096;
                drv = (drv < 0) ? -((-drv) >>> 24) : (drv >>> 24);
                r.drive = DRIVE_W'(clip(drv, DRIVE_MIN, DRIVE_MAX));
                r.tilt = ANGLE_W'(angle);
                r.ready = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_drive(logic [DRIVE_W-1:0] drive, logic [ANGLE_W-1:0] tilt,
                                  logic ready);
            drive_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: drive %0d tilt %0d ready %0b",
                             $signed(drive), $signed(tilt), ready);
                return;
            end
            e = expected_q.pop_front();
            if (drive !== e.drive || tilt !== e.tilt || ready !== e.ready) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected drive %0d tilt %0d ready %0b, ",
                             $signed(e.drive), $signed(e.tilt), e.ready,
                             "got drive %0d tilt %0d ready %0b",
                             $signed(drive), $signed(tilt), ready);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    drive_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int rx_hold = 0;

    balance_angle_pd_controller_core #(
        .CAL_SAMPLES(CAL_N)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [RAW_W-1:0] raw_of(int v);
        return (v < 0) ? '0 : ((v > RAW_MAX) ? RAW_MAX : RAW_W'(v));
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain(gain_kind_t kind);
        case (kind)
            GAIN_FULL: return GAIN_W'($urandom);
            GAIN_EXTREME: begin
                case ($urandom_range(3))
                    0: return GAIN_POS_MAX;
                    1: return GAIN_NEG_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            GAIN_MODERATE: return GAIN_W'(int'($urandom_range(1 << 15)) - (1 << 14));
            default: return GAIN_W'(int'($urandom_range(1 << 11)) - (1 << 10));
        endcase
    endfunction

    task automatic set_idling(idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 64 : ((mode == IDLE_BOTH) ? 36 : 0);
        stall_pct = (mode == IDLE_RECEIVER) ? 64 : ((mode == IDLE_BOTH) ? 36 : 0);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.load_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // accel_zero goes out with junk in the unused upper bits
    task automatic configure(input logic [RAW_W-1:0] zero, input logic [GAIN_W-1:0] gg,
                             input logic [GAIN_W-1:0] ag, input logic [GAIN_W-1:0] kp,
                             input logic [GAIN_W-1:0] kd);
        drain();
        repeat (4) @(negedge aclk);
        write_reg(REG_ACCEL_ZERO, CFG_DATA_W'({$urandom, zero}));
        write_reg(REG_GYRO_GAIN, gg);
        write_reg(REG_ACCEL_GAIN, ag);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KD_GAIN, kd);
        for (int i = REG_KD_GAIN + 1; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] accel_raw,
                               input logic [RAW_W-1:0] gyro_raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {gyro_raw, accel_raw};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(accel_raw, gyro_raw);
        @(negedge aclk);
    endtask

    task automatic send_corners();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, '0);
    endtask

    task automatic run_random(input int count);
        int a, g;
        repeat (count) begin
            case ($urandom_range(3))
                0: begin
                    // close to the balance point
                    a = int'(sb.zero_pt) + int'($urandom_range(64)) - 32;
                    g = int'(sb.rate_offset) + int'($urandom_range(64)) - 32;
                end
                1: begin
                    a = $urandom_range(1) ? int'(RAW_MAX) : 0;
                    g = $urandom_range(1) ? int'(RAW_MAX) : 0;
                end
                default: begin
                    a = $urandom_range(RAW_MAX);
                    g = $urandom_range(RAW_MAX);
                end
            endcase
            send_sample(raw_of(a), raw_of(g));
        end
    endtask

    // result side: stalls, long hold-off and checking
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = ($urandom_range(99) >= stall_pct);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_drive(m_tdata[DRIVE_W-1:0], m_tdata[DRIVE_W +: ANGLE_W], m_tuser);
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        gain_kind_t kind;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        set_idling(IDLE_NONE);

        // gyro offset calibration, kept low so the rate can reach near full scale
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, '0);
        repeat (CAL_N - 2) send_sample(RAW_W'($urandom), RAW_W'($urandom_range(127)));
        repeat (4) send_sample(RAW_W'($urandom), RAW_W'($urandom));

        configure(RAW_MAX, GAIN_POS_MAX, GAIN_POS_MAX, GAIN_POS_MAX, GAIN_POS_MAX);
        send_corners();
        configure('0, GAIN_NEG_MAX, GAIN_NEG_MAX, GAIN_NEG_MAX, GAIN_NEG_MAX);
        send_corners();
        configure(ACCEL_ZERO_RST, rand_gain(GAIN_FINE), rand_gain(GAIN_FINE),
                  rand_gain(GAIN_FINE), rand_gain(GAIN_FINE));
        send_corners();

        for (int p = 0; p < 12; p++) begin
            kind = gain_kind_t'($urandom_range(3));
            configure(RAW_W'($urandom), rand_gain(kind), rand_gain(kind),
                      rand_gain(kind), rand_gain(kind));
            set_idling(idle_mode_t'(p % 4));
            if (p == 0) rx_hold = 300;
            if (p == 5) begin
                run_random(50);
                drain();
                run_random(50);
            end else begin
                run_random(100);
            end
        end

        // drive the angle estimate into saturation
        configure(RAW_MAX, GAIN_POS_MAX, GAIN_POS_MAX, rand_gain(GAIN_FULL),
                  rand_gain(GAIN_FULL));
        set_idling(IDLE_NONE);
        repeat (8) send_sample('0, RAW_MAX);
        configure(RAW_W'($urandom), rand_gain(GAIN_MODERATE), rand_gain(GAIN_MODERATE),
                  rand_gain(GAIN_FULL), rand_gain(GAIN_FULL));
        set_idling(IDLE_BOTH);
        run_random(50);

        drain();
        repeat (8) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bapd_pkg.sv
hdl/bapd_cal.sv
hdl/bapd_filter.sv
hdl/balance_angle_pd_controller_core.sv
tb/tb.sv
